// ----- src/chd_pkg.sv -----
package chd_pkg;

  localparam int LINE_BYTES    = 128;
  localparam int SUFFIX_WINDOW = 24;
  localparam int MAX_RESULTS   = 64;

  localparam logic [6:0] MHL_RESET = 7'd60;
  localparam logic [6:0] TMC_RESET = 7'd30;

  localparam logic [2:0] ADDR_MHL = 3'd0;
  localparam logic [2:0] ADDR_TMC = 3'd4;

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;

  localparam logic [7:0] BOM_0 = 8'hEF;
  localparam logic [7:0] BOM_1 = 8'hBB;
  localparam logic [7:0] BOM_2 = 8'hBF;

  typedef struct packed {
    logic take;
    logic prep;
    logic scan;
    logic eval;
    logic read;
    logic sent;
  } cmd_t;

  typedef struct packed {
    logic fin;
    logic scan_ok;
    logic scan_done;
    logic hit;
    logic last;
  } status_t;

  function automatic logic [7:0] word_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = "c";
      3'd1: c = "h";
      3'd2: c = "a";
      3'd3: c = "p";
      3'd4: c = "t";
      3'd5: c = "e";
      3'd6: c = "r";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] utf8_len(input logic [7:0] b);
    logic [2:0] n;
    if (b < 8'h80) n = 3'd1;
    else if (b < 8'hE0) n = 3'd2;
    else if (b < 8'hF0) n = 3'd3;
    else n = 3'd4;
    return n;
  endfunction

endpackage

// ----- src/chd_if.sv -----
interface chd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;
  logic       end_of_file;

  modport source (output valid, data_byte, start_of_file, end_of_file, input ready);
  modport sink (input valid, data_byte, start_of_file, end_of_file, output ready);
endinterface

interface chd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] heading_offset;
  logic [7:0]  title_byte;
  logic        title_last;

  modport source (output valid, heading_offset, title_byte, title_last, input ready);
  modport sink (input valid, heading_offset, title_byte, title_last, output ready);
endinterface

// ----- src/chd_ctrl.sv -----
module chd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  chd_pkg::status_t status_i,
  output chd_pkg::cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PREP = 6'b000010,
    S_SCAN = 6'b000100,
    S_EVAL = 6'b001000,
    S_READ = 6'b010000,
    S_SEND = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = (state_q == S_IDLE);
    out_valid_o = (state_q == S_SEND);
    case (state_q)
      S_IDLE: begin
        cmd_o.take = in_valid_i;
        if (in_valid_i && status_i.fin) state_d = S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d = status_i.scan_ok ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) state_d = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d = status_i.hit ? S_READ : S_IDLE;
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d = S_SEND;
      end
      S_SEND: begin
        if (out_ready_i) begin
          cmd_o.sent = 1'b1;
          state_d = status_i.last ? S_IDLE : S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule

// ----- src/chd_datapath.sv -----
module chd_datapath #(
  parameter int LINE_BYTES    = chd_pkg::LINE_BYTES,
  parameter int SUFFIX_WINDOW = chd_pkg::SUFFIX_WINDOW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  chd_pkg::cmd_t    cmd_i,
  output chd_pkg::status_t status_o,
  input  logic [7:0]       data_byte_i,
  input  logic             start_of_file_i,
  input  logic             end_of_file_i,
  input  logic [6:0]       max_heading_len_i,
  input  logic [6:0]       title_max_chars_i,
  output logic [31:0]      heading_offset_o,
  output logic [7:0]       title_byte_o,
  output logic             title_last_o
);

  localparam int FW    = $clog2(LINE_BYTES);
  localparam int AW    = $clog2(LINE_BYTES - 1);
  localparam int TW    = FW + 1;
  localparam int CW    = FW + 8;
  localparam int RW    = $clog2(chd_pkg::MAX_RESULTS + 1);
  localparam int DEPTH = LINE_BYTES - 1;

  typedef enum logic [4:0] {
    EN_IND  = 5'b00001,
    EN_WORD = 5'b00010,
    EN_SEP  = 5'b00100,
    EN_BLK  = 5'b01000,
    EN_DONE = 5'b10000
  } en_e;

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_q;

  logic [FW-1:0] fill_q;
  logic [31:0]   bc_q, ls_q, off_q;
  logic          mp_q;
  logic [7:0]    b0_q, b1_q, b2_q;
  logic [FW-1:0] sn_q, st_q, eff_q;

  logic [FW-1:0] ra_q, pp_q;
  logic          pv_q;
  logic [7:0]    prev1_q, prev2_q;
  logic [FW-1:0] lead_ko_q, cand_ko_q, lead_zh_q, cand_zh_q;
  logic          lead_ko_v_q, cand_ko_v_q, lead_zh_v_q, cand_zh_v_q;
  logic          hit_ko_q, hit_zh_q, hit_en_q;
  en_e           en_q;
  logic [2:0]    en_idx_q, en_ind_q;
  logic [TW-1:0] tn_q;
  logic [6:0]    chars_q;
  logic [RW-1:0] tl_q, k_q;

  logic [FW-1:0] fill_eff, sn_term, sn_eof;
  logic [31:0]   bc_base, bc_new, ls_base;
  logic          term, store;

  logic          strip;
  logic [FW-1:0] st_c, eff_c;

  logic          issue, proc, rd_en;
  logic [8:0]    a9;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0]    b, lc, uc;
  logic          blank, adig, fdig, roman;
  logic          ko_lead, zh_lead, ko_suf, zh_suf, win_ko, win_zh;
  logic [6:0]    maxc;
  logic [8:0]    t9;
  logic [RW-1:0] tl_c;
  logic          last;

  // word intake
  always_comb begin
    fill_eff = start_of_file_i ? '0 : fill_q;
    bc_base  = start_of_file_i ? '0 : bc_q;
    ls_base  = start_of_file_i ? '0 : ls_q;
    bc_new   = (bc_base == 32'hFFFF_FFFF) ? bc_base : bc_base + 32'd1;
    term     = (data_byte_i == chd_pkg::CH_LF) || (data_byte_i == chd_pkg::CH_CR) ||
               (fill_eff >= FW'(LINE_BYTES - 1));
    store    = !term;
    sn_term  = fill_eff;
    sn_eof   = fill_eff + FW'(1);
    wr_addr  = fill_eff[AW-1:0];
  end

  // mark strip and length window
  always_comb begin
    strip = mp_q && (sn_q >= FW'(3)) && (b0_q == chd_pkg::BOM_0) &&
            (b1_q == chd_pkg::BOM_1) && (b2_q == chd_pkg::BOM_2);
    st_c  = strip ? FW'(3) : '0;
    eff_c = sn_q - st_c;
  end

  // scan byte classification
  always_comb begin
    issue   = cmd_i.scan && (ra_q < eff_q);
    proc    = cmd_i.scan && pv_q;
    rd_en   = issue || cmd_i.read;
    a9      = 9'(st_q) + (cmd_i.read ? 9'(k_q) : 9'(ra_q));
    rd_addr = a9[AW-1:0];
    b       = rd_data_q;
    lc      = (b inside {[8'h41:8'h5A]}) ? b + 8'd32 : b;
    uc      = (b inside {[8'h61:8'h7A]}) ? b - 8'd32 : b;
    blank   = (b == chd_pkg::CH_SP) || (b == chd_pkg::CH_TAB);
    adig    = b inside {[8'h30:8'h39]};
    fdig    = (prev2_q == 8'hEF) && (prev1_q == 8'hBC) && (b inside {[8'h90:8'h99]});
    roman   = uc inside {"I", "V", "X", "L", "C", "D", "M"};
    ko_lead = (prev2_q == 8'hEC) && (prev1_q == 8'hA0) && (b == 8'h9C);
    zh_lead = (prev2_q == 8'hE7) && (prev1_q == 8'hAC) && (b == 8'hAC);
    ko_suf  = ({prev2_q, prev1_q, b} == 24'hEC9EA5) || ({prev2_q, prev1_q, b} == 24'hED9994) ||
              ({prev2_q, prev1_q, b} == 24'hED8EB8) || ({prev2_q, prev1_q, b} == 24'hED9A8C) ||
              ({prev2_q, prev1_q, b} == 24'hEBB680);
    zh_suf  = ({prev2_q, prev1_q, b} == 24'hE7ABA0) || ({prev2_q, prev1_q, b} == 24'hE88A82) ||
              ({prev2_q, prev1_q, b} == 24'hE59B9E);
    win_ko  = cand_ko_v_q &&
              (CW'(cand_ko_q) + CW'(SUFFIX_WINDOW) >= CW'(pp_q) + CW'(1));
    win_zh  = cand_zh_v_q &&
              (CW'(cand_zh_q) + CW'(SUFFIX_WINDOW) >= CW'(pp_q) + CW'(1));
    maxc    = (title_max_chars_i == 7'd0) ? 7'd1 : title_max_chars_i;
    t9      = 9'(tn_q);
    if (9'(eff_q) < t9) t9 = 9'(eff_q);
    if (t9 > 9'(chd_pkg::MAX_RESULTS)) t9 = 9'(chd_pkg::MAX_RESULTS);
    tl_c    = t9[RW-1:0];
    last    = (k_q == tl_q - RW'(1));
  end

  always_comb begin
    status_o.fin       = term ? (fill_eff != '0) : end_of_file_i;
    status_o.scan_ok   = (eff_c >= FW'(9)) && (8'(eff_c) <= 8'(max_heading_len_i));
    status_o.scan_done = pv_q && (pp_q == eff_q - FW'(1));
    status_o.hit       = hit_ko_q || hit_zh_q || hit_en_q;
    status_o.last      = last;
  end

  assign heading_offset_o = off_q;
  assign title_byte_o     = rd_data_q;
  assign title_last_o     = last;

  // line store
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && store) mem[wr_addr] <= data_byte_i;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  // line snapshot
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      if (store && fill_eff == FW'(0)) b0_q <= data_byte_i;
      if (store && fill_eff == FW'(1)) b1_q <= data_byte_i;
      if (store && fill_eff == FW'(2)) b2_q <= data_byte_i;
      if (term || end_of_file_i) begin
        off_q <= ls_base;
        sn_q  <= term ? sn_term : sn_eof;
      end
    end
    if (cmd_i.prep) begin
      st_q  <= st_c;
      eff_q <= eff_c;
    end
    if (cmd_i.eval) tl_q <= tl_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      bc_q        <= '0;
      ls_q        <= '0;
      mp_q        <= 1'b1;
      ra_q        <= '0;
      pp_q        <= '0;
      pv_q        <= 1'b0;
      prev1_q     <= '0;
      prev2_q     <= '0;
      lead_ko_q   <= '0;
      cand_ko_q   <= '0;
      lead_zh_q   <= '0;
      cand_zh_q   <= '0;
      lead_ko_v_q <= 1'b0;
      cand_ko_v_q <= 1'b0;
      lead_zh_v_q <= 1'b0;
      cand_zh_v_q <= 1'b0;
      hit_ko_q    <= 1'b0;
      hit_zh_q    <= 1'b0;
      hit_en_q    <= 1'b0;
      en_q        <= EN_IND;
      en_idx_q    <= '0;
      en_ind_q    <= '0;
      tn_q        <= '0;
      chars_q     <= '0;
      k_q         <= '0;
    end else begin
      if (cmd_i.take) begin
        bc_q <= bc_new;
        if (start_of_file_i) mp_q <= 1'b1;
        if (term || end_of_file_i) begin
          fill_q <= '0;
          ls_q   <= bc_new;
        end else begin
          fill_q <= sn_eof;
          ls_q   <= ls_base;
        end
      end
      if (cmd_i.prep) begin
        if (strip) mp_q <= 1'b0;
        ra_q        <= '0;
        pv_q        <= 1'b0;
        prev1_q     <= '0;
        prev2_q     <= '0;
        lead_ko_v_q <= 1'b0;
        cand_ko_v_q <= 1'b0;
        lead_zh_v_q <= 1'b0;
        cand_zh_v_q <= 1'b0;
        hit_ko_q    <= 1'b0;
        hit_zh_q    <= 1'b0;
        hit_en_q    <= 1'b0;
        en_q        <= EN_IND;
        en_idx_q    <= '0;
        en_ind_q    <= '0;
        tn_q        <= '0;
        chars_q     <= '0;
      end
      if (cmd_i.scan) begin
        if (issue) ra_q <= ra_q + FW'(1);
        pv_q <= issue;
        pp_q <= ra_q;
      end
      if (proc) begin
        prev2_q <= prev1_q;
        prev1_q <= b;
        if (ko_lead) begin
          lead_ko_q   <= pp_q - FW'(2);
          lead_ko_v_q <= 1'b1;
        end
        if (zh_lead) begin
          lead_zh_q   <= pp_q - FW'(2);
          lead_zh_v_q <= 1'b1;
        end
        if ((adig || fdig) && lead_ko_v_q) begin
          cand_ko_q   <= lead_ko_q;
          cand_ko_v_q <= 1'b1;
        end
        if ((adig || fdig) && lead_zh_v_q) begin
          cand_zh_q   <= lead_zh_q;
          cand_zh_v_q <= 1'b1;
        end
        if (ko_suf && win_ko) hit_ko_q <= 1'b1;
        if (zh_suf && win_zh) hit_zh_q <= 1'b1;
        // english heading
        case (en_q)
          EN_IND: begin
            if (blank) begin
              if (en_ind_q == 3'd4) en_q <= EN_DONE;
              else en_ind_q <= en_ind_q + 3'd1;
            end else if (8'(eff_q) < 8'(en_ind_q) + 8'd9) begin
              en_q <= EN_DONE;
            end else if (lc == chd_pkg::word_char(3'd0)) begin
              en_idx_q <= 3'd1;
              en_q     <= EN_WORD;
            end else begin
              en_q <= EN_DONE;
            end
          end
          EN_WORD: begin
            if (lc != chd_pkg::word_char(en_idx_q)) en_q <= EN_DONE;
            else if (en_idx_q == 3'd6) en_q <= EN_SEP;
            else en_idx_q <= en_idx_q + 3'd1;
          end
          EN_SEP: begin
            en_q <= blank ? EN_BLK : EN_DONE;
          end
          EN_BLK: begin
            if (!blank) begin
              if (adig || roman) hit_en_q <= 1'b1;
              en_q <= EN_DONE;
            end
          end
          EN_DONE: en_q <= EN_DONE;
          default: en_q <= EN_DONE;
        endcase
        // title length in characters
        if ((TW'(pp_q) == tn_q) && (chars_q < maxc)) begin
          tn_q    <= tn_q + TW'(chd_pkg::utf8_len(b));
          chars_q <= chars_q + 7'd1;
        end
      end
      if (cmd_i.eval) k_q <= '0;
      if (cmd_i.sent) k_q <= k_q + RW'(1);
    end
  end

endmodule

// ----- src/chapter_heading_detector.sv -----
// chapter heading detector
// in_i carries one file byte per word with start_of_file and end_of_file
// flags; out_o carries one title byte per word together with the line's
// start offset, title_last marking the final byte of a heading.
// a byte that neither ends a line nor marks end of file is stored and
// leaves the block idle. a byte that closes a non-empty line is followed
// by a setup state, then, when the line is 9 bytes or longer and within
// max_heading_len, a scan over the line store (one registered read a
// cycle) and an evaluation state. a heading then sends its title one byte
// at a time (store read, then output), up to 64 bytes. in_i.ready is low
// from a non-empty line's end until it is dropped or its title is sent.
// a stalled receiver holds the output word and the whole block.
// reset clears the counters, the line fill and sets the mark-pending flag;
// config registers return to 60 and 30. the line store needs no clearing.
// config writes go through the apb port at byte addresses 0 and 4.
module chapter_heading_detector #(
  parameter int LINE_BYTES    = chd_pkg::LINE_BYTES,
  parameter int SUFFIX_WINDOW = chd_pkg::SUFFIX_WINDOW
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  chd_in_if.sink      in_i,
  chd_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [6:0]       mhl_q, tmc_q;
  chd_pkg::cmd_t    cmd;
  chd_pkg::status_t status;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mhl_q <= chd_pkg::MHL_RESET;
      tmc_q <= chd_pkg::TMC_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        chd_pkg::ADDR_MHL: mhl_q <= pwdata[6:0];
        chd_pkg::ADDR_TMC: tmc_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      chd_pkg::ADDR_MHL: prdata = {25'd0, mhl_q};
      chd_pkg::ADDR_TMC: prdata = {25'd0, tmc_q};
      default: prdata = '0;
    endcase
  end

  chd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  chd_datapath #(
    .LINE_BYTES    (LINE_BYTES),
    .SUFFIX_WINDOW (SUFFIX_WINDOW)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .data_byte_i       (in_i.data_byte),
    .start_of_file_i   (in_i.start_of_file),
    .end_of_file_i     (in_i.end_of_file),
    .max_heading_len_i (mhl_q),
    .title_max_chars_i (tmc_q),
    .heading_offset_o  (out_o.heading_offset),
    .title_byte_o      (out_o.title_byte),
    .title_last_o      (out_o.title_last)
  );

endmodule

// ----- src/chd_checker.sv -----
module chd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] heading_offset,
  input logic [7:0]  title_byte,
  input logic        title_last
);

  a_no_intake_while_sending: assert property (
    @(posedge clk_i) disable iff (!rst_ni) out_valid |-> !in_ready
  ) else $error("input ready while a title word is pending");

  a_title_continues: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid && out_ready && !title_last |=> !in_ready
  ) else $error("input reopened before the title ended");

  a_title_ends: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid && out_ready && title_last |=> !out_valid
  ) else $error("output still valid after the last title word");

  a_stall_holds: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid && !out_ready |=> out_valid && $stable(title_byte) &&
                                  $stable(heading_offset) && $stable(title_last)
  ) else $error("stalled output word changed");

endmodule

bind chapter_heading_detector chd_checker u_chd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready       (in_i.ready),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .heading_offset (out_o.heading_offset),
  .title_byte     (out_o.title_byte),
  .title_last     (out_o.title_last)
);

// ----- tb/chapter_heading_detector_test.sv -----
`timescale 1ns / 1ps

module chapter_heading_detector_test;

  class heading_scoreboard;
    typedef struct {
      logic [31:0] offset;
      logic [7:0]  tbyte;
      logic        last;
    } title_word_t;

    title_word_t title_q[$];
    logic [7:0]  line_buf[chd_pkg::LINE_BYTES];
    logic [7:0]  cur[$];
    int          fill;
    logic [31:0] count;
    logic [31:0] start;
    bit          bom_pending;
    int          max_len;
    int          max_chars;
    int          errors;

    function new();
      fill = 0;
      count = 0;
      start = 0;
      bom_pending = 1;
      max_len = int'(chd_pkg::MHL_RESET);
      max_chars = int'(chd_pkg::TMC_RESET);
      errors = 0;
    endfunction

    function bit tri_at(int i, logic [7:0] a, logic [7:0] b, logic [7:0] c);
      return i + 2 < cur.size() && cur[i] == a && cur[i+1] == b && cur[i+2] == c;
    endfunction

    function bit digit_in(int a, int b);
      for (int i = a; i < b; i++) begin
        if (cur[i] >= "0" && cur[i] <= "9") return 1;
        if (cur[i] == 8'hEF && i + 2 < b && cur[i+1] == 8'hBC &&
            cur[i+2] >= 8'h90 && cur[i+2] <= 8'h99) return 1;
      end
      return 0;
    endfunction

    function bit suffix_at(int j, bit korean);
      if (korean)
        return tri_at(j, 8'hEC, 8'h9E, 8'hA5) || tri_at(j, 8'hED, 8'h99, 8'h94) ||
               tri_at(j, 8'hED, 8'h8E, 8'hB8) || tri_at(j, 8'hED, 8'h9A, 8'h8C) ||
               tri_at(j, 8'hEB, 8'hB6, 8'h80);
      return tri_at(j, 8'hE7, 8'hAB, 8'hA0) || tri_at(j, 8'hE8, 8'h8A, 8'h82) ||
             tri_at(j, 8'hE5, 8'h9B, 8'h9E);
    endfunction

    function bit cjk_hit(bit korean);
      int n;
      int lim;
      bit lead;
      n = cur.size();
      if (n < 9) return 0;
      for (int i = 0; i <= (korean ? n - 7 : n - 6); i++) begin
        lead = korean ? tri_at(i, 8'hEC, 8'hA0, 8'h9C) : tri_at(i, 8'hE7, 8'hAC, 8'hAC);
        if (!lead) continue;
        lim = (i + chd_pkg::SUFFIX_WINDOW < n) ? i + chd_pkg::SUFFIX_WINDOW : n;
        for (int j = i + 3; j <= lim - 3; j++)
          if (suffix_at(j, korean) && digit_in(i + 3, j)) return 1;
      end
      return 0;
    endfunction

    function bit blank(logic [7:0] c);
      return c == chd_pkg::CH_SP || c == chd_pkg::CH_TAB;
    endfunction

    function bit english_hit();
      int n;
      int st;
      int pos;
      logic [7:0] c;
      n = cur.size();
      st = 0;
      if (n < 9) return 0;
      while (st < n && blank(cur[st])) begin
        st++;
        if (st > 4) return 0;
      end
      if (n - st < 9) return 0;
      for (int i = 0; i < 7; i++) begin
        c = cur[st+i];
        if (c >= "A" && c <= "Z") c = c + 8'd32;
        if (c != chd_pkg::word_char(i[2:0])) return 0;
      end
      pos = st + 7;
      if (!blank(cur[pos])) return 0;
      while (pos < n && blank(cur[pos])) pos++;
      if (pos >= n) return 0;
      c = cur[pos];
      if (c >= "0" && c <= "9") return 1;
      if (c >= "a" && c <= "z") c = c - 8'd32;
      return c == "I" || c == "V" || c == "X" || c == "L" || c == "C" ||
             c == "D" || c == "M";
    endfunction

    function void close_line();
      int st;
      int pos;
      int chars;
      int limit;
      title_word_t w;
      st = 0;
      pos = 0;
      chars = 0;
      limit = max_chars ? max_chars : 1;
      if (fill == 0) return;
      if (bom_pending && fill >= 3 && line_buf[0] == chd_pkg::BOM_0 &&
          line_buf[1] == chd_pkg::BOM_1 && line_buf[2] == chd_pkg::BOM_2) begin
        st = 3;
        bom_pending = 0;
      end
      cur.delete();
      for (int i = st; i < fill; i++) cur.insert(cur.size(), line_buf[i]);
      if (cur.size() == 0 || cur.size() > max_len) return;
      if (!(cjk_hit(1) || cjk_hit(0) || english_hit())) return;
      while (pos < cur.size() && chars < limit) begin
        pos += (cur[pos] < 8'h80) ? 1 : (cur[pos] < 8'hE0) ? 2 : (cur[pos] < 8'hF0) ? 3 : 4;
        chars++;
      end
      if (pos > cur.size()) pos = cur.size();
      if (pos > chd_pkg::MAX_RESULTS) pos = chd_pkg::MAX_RESULTS;
      for (int k = 0; k < pos; k++) begin
        w.offset = start;
        w.tbyte = cur[k];
        w.last = (k == pos - 1);
        title_q.insert(title_q.size(), w);
      end
    endfunction

    function void note_byte(logic [7:0] d, logic sof, logic eof);
      if (sof) begin
        count = 0;
        fill = 0;
        start = 0;
        bom_pending = 1;
      end
      if (count != 32'hFFFF_FFFF) count++;
      if (d == chd_pkg::CH_LF || d == chd_pkg::CH_CR || fill >= chd_pkg::LINE_BYTES - 1) begin
        close_line();
        fill = 0;
        start = count;
      end else begin
        line_buf[fill] = d;
        fill++;
      end
      if (eof && fill > 0) begin
        close_line();
        fill = 0;
        start = count;
      end
    endfunction

    function void check_word(logic [31:0] off, logic [7:0] b, logic last);
      title_word_t w;
      if (title_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: offset %h byte %h last %b", off, b, last);
        return;
      end
      w = title_q.pop_front();
      if (w.offset !== off || w.tbyte !== b || w.last !== last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected offset %h byte %h last %b, got %h %h %b",
                   w.offset, w.tbyte, w.last, off, b, last);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  chd_in_if  in_bus ();
  chd_out_if out_bus ();

  chapter_heading_detector dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus.sink),
    .out_o   (out_bus.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  heading_scoreboard sb = new();
  int send_idle;
  int recv_idle;
  bit hold_req;
  int hold_left;
  logic [7:0] file_q[$];

  always #5 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    hold_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready)
        sb.check_word(out_bus.heading_offset, out_bus.title_byte, out_bus.title_last);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 400;
      end
      if (hold_left > 0) hold_left--;
      out_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  task send_byte(logic [7:0] d, logic sof, logic eof);
    while ($urandom_range(99) < send_idle) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data_byte <= d;
    in_bus.start_of_file <= sof;
    in_bus.end_of_file <= eof;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    sb.note_byte(d, sof, eof);
  endtask

  task drain();
    in_bus.valid <= 1'b0;
    while (sb.title_q.size() != 0) @(posedge clk_i);
  endtask

  task reg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == chd_pkg::ADDR_MHL) sb.max_len = int'(data[6:0]);
    else sb.max_chars = int'(data[6:0]);
  endtask

  task send_file(bit with_sof);
    foreach (file_q[i])
      send_byte(file_q[i], with_sof && i == 0, i == file_q.size() - 1);
    file_q.delete();
  endtask

  function automatic void add_byte(logic [7:0] b);
    file_q.insert(file_q.size(), b);
  endfunction

  function automatic void add_text(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(4) == 0) begin
        add_byte(8'(8'hE0 + $urandom_range(15)));
        add_byte(8'(8'h80 + $urandom_range(63)));
        add_byte(8'(8'h80 + $urandom_range(63)));
      end else begin
        add_byte(8'(8'h20 + $urandom_range(94)));
      end
    end
  endfunction

  function automatic void add_digits();
    int k;
    k = $urandom_range(3);
    if (k == 0 && $urandom_range(1)) return;
    for (int i = 0; i <= k; i++) begin
      if ($urandom_range(2) == 0) begin
        add_byte(8'hEF);
        add_byte(8'hBC);
        add_byte(8'(8'h90 + $urandom_range(9)));
      end else begin
        add_byte(8'("0" + $urandom_range(9)));
      end
    end
  endfunction

  function automatic void add_line();
    logic [7:0] ko_suf[15] = '{8'hEC, 8'h9E, 8'hA5, 8'hED, 8'h99, 8'h94, 8'hED, 8'h8E,
                               8'hB8, 8'hED, 8'h9A, 8'h8C, 8'hEB, 8'hB6, 8'h80};
    logic [7:0] zh_suf[9] = '{8'hE7, 8'hAB, 8'hA0, 8'hE8, 8'h8A, 8'h82, 8'hE5, 8'h9B, 8'h9E};
    logic [7:0] roman[8] = '{"I", "V", "X", "L", "C", "D", "M", "Q"};
    logic [7:0] c;
    int kind;
    int s;
    kind = $urandom_range(11);
    if (kind <= 5) begin
      add_text($urandom_range(2) == 0 ? $urandom_range(3) : 0);
      if (kind <= 2) begin
        add_byte(8'hEC); add_byte(8'hA0); add_byte(8'h9C);
      end else begin
        add_byte(8'hE7); add_byte(8'hAC); add_byte(8'hAC);
      end
      add_digits();
      repeat ($urandom_range(5) == 0 ? $urandom_range(25) : $urandom_range(1))
        add_byte(chd_pkg::CH_SP);
      if (kind <= 2) begin
        s = $urandom_range(4) * 3;
        for (int i = 0; i < 3; i++) add_byte(ko_suf[s+i]);
      end else begin
        s = $urandom_range(2) * 3;
        for (int i = 0; i < 3; i++) add_byte(zh_suf[s+i]);
      end
      add_text($urandom_range(20));
    end else if (kind <= 8) begin
      repeat ($urandom_range(5))
        add_byte($urandom_range(1) ? chd_pkg::CH_SP : chd_pkg::CH_TAB);
      for (int i = 0; i < 7; i++) begin
        c = chd_pkg::word_char(i[2:0]);
        if ($urandom_range(1)) c = c - 8'd32;
        if ($urandom_range(30) == 0) c = c + 8'd1;
        add_byte(c);
      end
      repeat ($urandom_range(10) == 0 ? 0 : 1 + $urandom_range(2))
        add_byte($urandom_range(1) ? chd_pkg::CH_SP : chd_pkg::CH_TAB);
      if ($urandom_range(1)) c = 8'("0" + $urandom_range(9));
      else c = roman[$urandom_range(7)] + ($urandom_range(1) ? 8'd32 : 8'd0);
      add_byte(c);
      add_text($urandom_range(25));
    end else if (kind <= 10) begin
      repeat (1 + $urandom_range(20)) add_byte(8'($urandom_range(255)));
    end else begin
      repeat (120 + $urandom_range(20)) add_byte(8'(8'h20 + $urandom_range(94)));
    end
    case ($urandom_range(3))
      0: add_byte(chd_pkg::CH_CR);
      1: begin add_byte(chd_pkg::CH_CR); add_byte(chd_pkg::CH_LF); end
      default: add_byte(chd_pkg::CH_LF);
    endcase
  endfunction

  initial begin
    int cfg_len[5] = '{60, 127, 0, 9, 40};
    int cfg_chars[5] = '{30, 127, 1, 0, 3};
    int sent;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = chd_pkg::ADDR_MHL;
    pwdata = '0;
    hold_req = 0;
    in_bus.valid = 1'b0;
    in_bus.data_byte = '0;
    in_bus.start_of_file = 1'b0;
    in_bus.end_of_file = 1'b0;
    send_idle = 14;
    recv_idle = 87;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // marked korean heading, then an unterminated english one
    file_q = '{chd_pkg::BOM_0, chd_pkg::BOM_1, chd_pkg::BOM_2, 8'hEC, 8'hA0, 8'h9C,
               "1", 8'hEC, 8'h9E, 8'hA5, chd_pkg::CH_SP, "A", chd_pkg::CH_LF,
               "C", "h", "a", "P", "t", "e", "r", chd_pkg::CH_TAB, "v"};
    send_file(1);

    for (int p = 0; p < 5; p++) begin
      drain();
      repeat (300) @(posedge clk_i);
      if (p == 0) begin
        reg_write(chd_pkg::ADDR_TMC, cfg_chars[p]);
        reg_write(chd_pkg::ADDR_MHL, cfg_len[p]);
      end else begin
        reg_write(chd_pkg::ADDR_MHL, cfg_len[p]);
        reg_write(chd_pkg::ADDR_TMC, cfg_chars[p]);
      end
      send_idle = (p < 2) ? 14 : (p < 4) ? 87 : 0;
      recv_idle = (p < 2) ? 87 : (p < 4) ? 14 : 0;
      if (p == 1 || p == 4) hold_req = 1;
      sent = 0;
      while (sent < 20) begin
        if (p > 0 && $urandom_range(1)) begin
          add_byte(chd_pkg::BOM_0); add_byte(chd_pkg::BOM_1); add_byte(chd_pkg::BOM_2);
        end
        repeat (1 + $urandom_range(1)) add_line();
        if ($urandom_range(1)) void'(file_q.pop_back());
        sent += file_q.size();
        send_file($urandom_range(3) != 0);
        if ($urandom_range(4) == 0) drain();
      end
    end

    drain();
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.title_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
